// ----- rtl/rgb_led_panel_scan_driver_unit_assert.svh -----
// assertion macros for the led panel scan driver
`ifndef RGB_LED_PANEL_SCAN_DRIVER_UNIT_ASSERT_SVH
`define RGB_LED_PANEL_SCAN_DRIVER_UNIT_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define LPS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/lps_pkg.sv -----
// shared types and constants for the led panel scan driver
package lps_pkg;

	localparam int PANEL_ROWS_DEF = 32;
	localparam int PANEL_COLS_DEF = 32;
	localparam int HALF_ROWS_DEF  = 16;

	localparam logic [15:0] DWELL_RESET = 16'd250;

	localparam logic [1:0] ACT_OR   = 2'd0;
	localparam logic [1:0] ACT_WR   = 2'd1;
	localparam logic [1:0] ACT_TICK = 2'd2;

	localparam logic [5:0] TOP_MASK = 6'h07;
	localparam logic [5:0] BOT_MASK = 6'h38;

	typedef enum logic [2:0] {
		PH_SHIFT = 3'b001,
		PH_LATCH = 3'b010,
		PH_DWELL = 3'b100
	} phase_t;

	typedef struct packed {
		logic [1:0] action;
		logic [4:0] pixel_row;
		logic [4:0] pixel_col;
		logic [5:0] colour;
	} in_word_t;

	typedef struct packed {
		logic [3:0] row_addr;
		logic [2:0] top_rgb;
		logic [2:0] bottom_rgb;
		logic       shift_clock;
		logic       latch_strobe;
		logic       display_on;
	} out_word_t;

	typedef struct packed {
		logic [3:0] row_addr;
		logic       shift;
		logic       latch;
		logic       lit;
	} tick_info_t;

endpackage

// ----- rtl/lps_store.sv -----
// frame store memory with clearing pass after reset
module lps_store #(
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [5:0]               wr_data,
	output logic [5:0]               rd_data,
	output logic                     clearing
);
	import lps_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic [5:0]    mem [DEPTH];
	logic [AW-1:0] clr_addr_q;
	logic          clr_q;
	logic          we;
	logic [AW-1:0] wa;
	logic [5:0]    wd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_comb begin
		we = clr_q | wr_en;
		wa = clr_q ? clr_addr_q : wr_addr;
		wd = clr_q ? 6'd0 : wr_data;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	assign clearing = clr_q;

endmodule

// ----- rtl/lps_scan.sv -----
// scan sequencer: line, column, phase and dwell counters
module lps_scan #(
	parameter int PANEL_ROWS = 32,
	parameter int PANEL_COLS = 32,
	parameter int HALF_ROWS  = 16
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      tick,
	input  logic [15:0]                               dwell_ticks,
	output lps_pkg::tick_info_t                       info,
	output logic [$clog2(PANEL_ROWS*PANEL_COLS)-1:0]  scan_addr
);
	import lps_pkg::*;

	localparam int AW = $clog2(PANEL_ROWS * PANEL_COLS);
	localparam int LW = $clog2(PANEL_ROWS);
	localparam int CW = $clog2(PANEL_COLS);
	localparam int HW = $clog2(HALF_ROWS);

	logic [LW-1:0] line_q;
	logic [CW-1:0] col_q;
	logic [HW-1:0] half_q;
	logic [15:0]   dwell_q;
	phase_t        phase_q;
	logic [15:0]   limit;
	logic          dwell_end;

	always_comb begin
		limit     = (dwell_ticks == 16'd0) ? 16'd1 : dwell_ticks;
		dwell_end = ({1'b0, dwell_q} + 17'd1) >= {1'b0, limit};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q  <= '0;
			col_q   <= '0;
			half_q  <= '0;
			dwell_q <= '0;
			phase_q <= PH_SHIFT;
		end else if (tick) begin
			case (phase_q)
				PH_LATCH: begin
					dwell_q <= '0;
					phase_q <= PH_DWELL;
				end
				PH_DWELL: begin
					if (dwell_end) begin
						col_q   <= '0;
						dwell_q <= '0;
						phase_q <= PH_SHIFT;
						if (line_q == LW'(PANEL_ROWS - 1)) begin
							line_q <= '0;
							half_q <= '0;
						end else begin
							line_q <= line_q + LW'(1);
							half_q <= (half_q == HW'(HALF_ROWS - 1)) ? '0 : half_q + HW'(1);
						end
					end else begin
						dwell_q <= dwell_q + 16'd1;
					end
				end
				default: begin
					if (col_q == CW'(PANEL_COLS - 1)) begin
						col_q   <= '0;
						phase_q <= PH_LATCH;
					end else begin
						col_q   <= col_q + CW'(1);
						phase_q <= PH_SHIFT;
					end
				end
			endcase
		end
	end

	always_comb begin
		info.row_addr = 4'(half_q);
		info.latch    = (phase_q == PH_LATCH);
		info.lit      = (phase_q == PH_DWELL);
		info.shift    = !info.latch && !info.lit;
		scan_addr     = AW'(int'(line_q) * PANEL_COLS + int'(col_q));
	end

endmodule

// ----- rtl/rgb_led_panel_scan_driver_unit.sv -----
// top level of the led panel scan driver
//
//  channel  direction  handshake           word
//  cmd      in         start / busy        action, pixel_row, pixel_col, colour
//  result   out        done (no backpress) row_addr, rgb halves, panel strobes
//  cfg      in         cfg_valid/cfg_ready dwell_ticks
//
// one word per cycle while busy is low; a tick's result is registered through
// the memory read, then the result register; pixel writes give no result
// after reset busy stays high while the
// frame store is cleared one pixel per cycle; cfg writes are taken meanwhile
// results cannot be stalled; cfg_ready is always high
module rgb_led_panel_scan_driver_unit #(
	parameter int PANEL_ROWS = lps_pkg::PANEL_ROWS_DEF,
	parameter int PANEL_COLS = lps_pkg::PANEL_COLS_DEF,
	parameter int HALF_ROWS  = lps_pkg::HALF_ROWS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  lps_pkg::in_word_t  cmd,
	output logic               done,
	output lps_pkg::out_word_t result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [15:0]        cfg_data
);
	import lps_pkg::*;

	`include "rgb_led_panel_scan_driver_unit_assert.svh"

	localparam int AW = $clog2(PANEL_ROWS * PANEL_COLS);

	logic [15:0]   dwell_ticks_q;
	logic          accept;
	logic          is_tick;
	logic          is_wr;
	logic          pix_ok;
	logic [AW-1:0] pix_addr;
	logic [AW-1:0] scan_addr;
	logic [AW-1:0] rd_addr;
	logic [5:0]    wval;
	tick_info_t    info;

	logic          wr_s1;
	logic          or_s1;
	logic [AW-1:0] addr_s1;
	logic [5:0]    wval_s1;
	logic          tick_s1;
	tick_info_t    info_s1;
	logic          byp_s1;
	logic [5:0]    bypd_s1;

	logic [5:0]    rd_data;
	logic [5:0]    old_px;
	logic [5:0]    new_px;
	logic          clearing;

	logic          done_q;
	out_word_t     result_q;

	assign cfg_ready = 1'b1;
	assign busy      = clearing;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dwell_ticks_q <= DWELL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			dwell_ticks_q <= cfg_data;
		end
	end

	always_comb begin
		accept   = start && !busy;
		is_tick  = accept && (cmd.action == ACT_TICK);
		pix_ok   = (int'(cmd.pixel_row) < PANEL_ROWS) && (int'(cmd.pixel_col) < PANEL_COLS);
		is_wr    = accept && pix_ok && (cmd.action == ACT_OR || cmd.action == ACT_WR);
		pix_addr = AW'(int'(cmd.pixel_row) * PANEL_COLS + int'(cmd.pixel_col));
		rd_addr  = is_tick ? scan_addr : pix_addr;
		if (cmd.action == ACT_WR) begin
			wval = cmd.colour;
		end else if (int'(cmd.pixel_row) < HALF_ROWS) begin
			wval = cmd.colour & TOP_MASK;
		end else begin
			wval = cmd.colour & BOT_MASK;
		end
	end

	lps_scan #(
		.PANEL_ROWS (PANEL_ROWS),
		.PANEL_COLS (PANEL_COLS),
		.HALF_ROWS  (HALF_ROWS)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.tick        (is_tick),
		.dwell_ticks (dwell_ticks_q),
		.info        (info),
		.scan_addr   (scan_addr)
	);

	always_comb begin
		old_px = byp_s1 ? bypd_s1 : rd_data;
		new_px = or_s1 ? (old_px | wval_s1) : wval_s1;
	end

	lps_store #(
		.DEPTH (PANEL_ROWS * PANEL_COLS)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (is_tick || is_wr),
		.rd_addr  (rd_addr),
		.wr_en    (wr_s1),
		.wr_addr  (addr_s1),
		.wr_data  (new_px),
		.rd_data  (rd_data),
		.clearing (clearing)
	);

	// stage 1 control and the done register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_s1   <= 1'b0;
			tick_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			wr_s1   <= is_wr;
			tick_s1 <= is_tick;
			done_q  <= tick_s1;
		end
	end

	// stage 1 payload and write-to-read forwarding
	always_ff @(posedge clk) begin
		or_s1   <= (cmd.action == ACT_OR);
		addr_s1 <= pix_addr;
		wval_s1 <= wval;
		info_s1 <= info;
		byp_s1  <= wr_s1 && (addr_s1 == rd_addr);
		bypd_s1 <= new_px;
	end

	always_ff @(posedge clk) begin
		result_q.row_addr     <= info_s1.row_addr;
		result_q.top_rgb      <= info_s1.shift ? old_px[2:0] : 3'd0;
		result_q.bottom_rgb   <= info_s1.shift ? old_px[5:3] : 3'd0;
		result_q.shift_clock  <= info_s1.shift;
		result_q.latch_strobe <= info_s1.latch;
		result_q.display_on   <= info_s1.lit;
	end

	assign done   = done_q;
	assign result = result_q;

	`LPS_ASSERT_NOW(a_done_from_tick, done,
		$past(start && !busy, 2) && $past(cmd.action == ACT_TICK, 2),
		"result without a tick two cycles before")
	`LPS_ASSERT_NOW(a_one_strobe, done,
		$onehot({result.shift_clock, result.latch_strobe, result.display_on}),
		"result must carry exactly one panel strobe")
	`LPS_ASSERT_NOW(a_dark_outside_shift, done && !result.shift_clock,
		result.top_rgb == 3'd0 && result.bottom_rgb == 3'd0,
		"colour outside a shift tick")
	`LPS_ASSERT_NEXT(a_no_result_while_clearing, busy, !done,
		"result during frame store clearing")

endmodule
